@@ rtl/core/aisd_pkg.sv @@
`timescale 1ns / 1ps
// aisd_pkg: shared types and constants for the +IPD stream deframer
// no dependencies

package aisd_pkg;

  // result kinds
  localparam logic [1:0] KIND_FRAMING = 2'd0;
  localparam logic [1:0] KIND_TEXT    = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;

  // input word action codes
  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  localparam int          WIN_DEPTH = 17;
  localparam logic [19:0] MAX_LEN   = 20'd65535;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // frame prefix, first char in the top byte
  localparam logic [39:0] HDR_TEXT = "+IPD,";

  // disconnect strings, first char in the top byte
  localparam int           DISC_A_LEN = 15;
  localparam int           DISC_B_LEN = 6;
  localparam int           DISC_C_LEN = 17;
  localparam logic [119:0] DISC_A     = "WIFI DISCONNECT";
  localparam logic [47:0]  DISC_B     = "CLOSED";
  localparam logic [135:0] DISC_C     = "link is not valid";

  typedef struct packed {
    logic       action;
    logic [7:0] in_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       payload_last;
    logic       link_closed;
    logic       length_error;
  } result_t;

  // per-word control from the top level to the state holders
  typedef struct packed {
    logic       step;
    logic       clear;
    logic [7:0] data;
  } step_t;

  // parser result for the word being processed
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       payload_last;
    logic       rec_en;
    logic       length_error;
  } prs_out_t;

endpackage

@@ rtl/core/aisd_if.sv @@
`timescale 1ns / 1ps
// aisd_if: valid/ready stream interfaces for the deframer input and output words
// no dependencies

interface aisd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] in_byte;

  modport source (output valid, output action, output in_byte, input ready);
  modport sink   (input valid, input action, input in_byte, output ready);
endinterface

interface aisd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       payload_last;
  logic       link_closed;
  logic       length_error;

  modport source (output valid, output kind, output out_byte, output payload_last,
                  output link_closed, output length_error, input ready);
  modport sink   (input valid, input kind, input out_byte, input payload_last,
                  input link_closed, input length_error, output ready);
endinterface

@@ rtl/core/aisd_parser.sv @@
`timescale 1ns / 1ps
// aisd_parser: prefix hunt, length read, header skip and payload count
// depends on aisd_pkg

module aisd_parser (
  input  logic              clk,
  input  logic              rst,
  input  aisd_pkg::step_t   ctl,
  output aisd_pkg::prs_out_t res
);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_LEN     = 2'd1,
    PH_SKIP    = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  prefix_matched, prefix_matched_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic        error_flag, error_flag_next;

  logic [2:0]  pos;
  logic [7:0]  hdr_char;
  logic [19:0] len_val;
  logic        is_digit;

  always_comb begin
    pos = (prefix_matched > 3'd4) ? 3'd0 : prefix_matched;
    case (pos)
      3'd0:    hdr_char = aisd_pkg::HDR_TEXT[39:32];
      3'd1:    hdr_char = aisd_pkg::HDR_TEXT[31:24];
      3'd2:    hdr_char = aisd_pkg::HDR_TEXT[23:16];
      3'd3:    hdr_char = aisd_pkg::HDR_TEXT[15:8];
      default: hdr_char = aisd_pkg::HDR_TEXT[7:0];
    endcase
    is_digit = (ctl.data >= aisd_pkg::CH_ZERO) && (ctl.data <= aisd_pkg::CH_NINE);
    // len * 10 + digit as shift-add
    len_val = {1'b0, bytes_left, 3'b000} + {3'b000, bytes_left, 1'b0}
            + {16'd0, 4'(ctl.data - aisd_pkg::CH_ZERO)};
  end

  always_comb begin
    phase_next          = phase;
    prefix_matched_next = prefix_matched;
    bytes_left_next     = bytes_left;
    error_flag_next     = error_flag;
    res                 = '0;

    if (ctl.clear) begin
      phase_next          = PH_HUNT;
      prefix_matched_next = 3'd0;
      bytes_left_next     = 16'd0;
      error_flag_next     = 1'b0;
    end else begin
      case (phase)
        PH_PAYLOAD: begin
          res.kind     = aisd_pkg::KIND_PAYLOAD;
          res.out_byte = ctl.data;
          if (bytes_left <= 16'd1) begin
            res.payload_last    = 1'b1;
            bytes_left_next     = 16'd0;
            phase_next          = PH_HUNT;
            prefix_matched_next = 3'd0;
          end else begin
            bytes_left_next = bytes_left - 16'd1;
          end
        end
        PH_HUNT: begin
          if (ctl.data == hdr_char) begin
            if (pos == 3'd4) begin
              phase_next          = PH_LEN;
              bytes_left_next     = 16'd0;
              prefix_matched_next = 3'd0;
            end else begin
              prefix_matched_next = pos + 3'd1;
            end
          end else begin
            res.rec_en = 1'b1;
            if (ctl.data == aisd_pkg::CH_PLUS) begin
              prefix_matched_next = 3'd1;
            end else begin
              prefix_matched_next = 3'd0;
              res.kind            = aisd_pkg::KIND_TEXT;
              res.out_byte        = ctl.data;
            end
          end
        end
        PH_LEN: begin
          if (is_digit) begin
            if (len_val > aisd_pkg::MAX_LEN) begin
              error_flag_next     = 1'b1;
              bytes_left_next     = 16'd0;
              phase_next          = PH_HUNT;
              prefix_matched_next = 3'd0;
            end else begin
              bytes_left_next = len_val[15:0];
            end
          end else if (ctl.data == aisd_pkg::CH_COLON) begin
            phase_next          = (bytes_left == 16'd0) ? PH_HUNT : PH_PAYLOAD;
            prefix_matched_next = 3'd0;
          end else if (ctl.data == aisd_pkg::CH_COMMA) begin
            phase_next = PH_SKIP;
          end else begin
            phase_next          = PH_HUNT;
            prefix_matched_next = 3'd0;
          end
        end
        default: begin
          if (ctl.data == aisd_pkg::CH_COLON) begin
            phase_next          = (bytes_left == 16'd0) ? PH_HUNT : PH_PAYLOAD;
            prefix_matched_next = 3'd0;
          end
        end
      endcase
    end
    res.length_error = error_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      prefix_matched <= 3'd0;
      bytes_left     <= 16'd0;
      error_flag     <= 1'b0;
    end else if (ctl.step) begin
      phase          <= phase_next;
      prefix_matched <= prefix_matched_next;
      bytes_left     <= bytes_left_next;
      error_flag     <= error_flag_next;
    end
  end

endmodule

@@ rtl/core/aisd_window.sv @@
`timescale 1ns / 1ps
// aisd_window: 17-byte text window and disconnect string match
// depends on aisd_pkg

module aisd_window (
  input  logic            clk,
  input  logic            rst,
  input  aisd_pkg::step_t ctl,
  input  logic            rec_en,
  output logic            closed_next
);

  // entry WIN_DEPTH-1 is the newest byte
  logic [aisd_pkg::WIN_DEPTH-1:0][7:0] win, win_next;
  logic closed_flag;
  logic [aisd_pkg::WIN_DEPTH-1:0][7:0] shifted;
  logic match_a, match_b, match_c;

  always_comb begin
    shifted[aisd_pkg::WIN_DEPTH-2:0] = win[aisd_pkg::WIN_DEPTH-1:1];
    shifted[aisd_pkg::WIN_DEPTH-1]   = ctl.data;

    match_a = 1'b1;
    for (int i = 0; i < aisd_pkg::DISC_A_LEN; i++) begin
      if (shifted[aisd_pkg::WIN_DEPTH - aisd_pkg::DISC_A_LEN + i]
          != aisd_pkg::DISC_A[8*(aisd_pkg::DISC_A_LEN-1-i) +: 8])
        match_a = 1'b0;
    end
    match_b = 1'b1;
    for (int i = 0; i < aisd_pkg::DISC_B_LEN; i++) begin
      if (shifted[aisd_pkg::WIN_DEPTH - aisd_pkg::DISC_B_LEN + i]
          != aisd_pkg::DISC_B[8*(aisd_pkg::DISC_B_LEN-1-i) +: 8])
        match_b = 1'b0;
    end
    match_c = 1'b1;
    for (int i = 0; i < aisd_pkg::DISC_C_LEN; i++) begin
      if (shifted[aisd_pkg::WIN_DEPTH - aisd_pkg::DISC_C_LEN + i]
          != aisd_pkg::DISC_C[8*(aisd_pkg::DISC_C_LEN-1-i) +: 8])
        match_c = 1'b0;
    end

    if (ctl.clear) begin
      win_next    = '0;
      closed_next = 1'b0;
    end else if (rec_en) begin
      win_next    = shifted;
      closed_next = closed_flag | match_a | match_b | match_c;
    end else begin
      win_next    = win;
      closed_next = closed_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win         <= '0;
      closed_flag <= 1'b0;
    end else if (ctl.step) begin
      win         <= win_next;
      closed_flag <= closed_next;
    end
  end

endmodule

@@ rtl/core/at_ipd_stream_deframer.sv @@
`timescale 1ns / 1ps
// at_ipd_stream_deframer: top level of the +IPD modem stream deframer
// depends on aisd_pkg, aisd_if, aisd_parser, aisd_window
//
// usage
//   rx carries one word per received modem byte (action = 0) or a clear
//   request (action = 1); tx returns exactly one result word per rx word:
//   kind (framing / AT text / payload), the byte, a last-payload mark and
//   the sticky link-closed and length-error flags after that word
//   a word taken from rx sits in the input register, is parsed
//   combinationally and then held in the result register that drives tx;
//   throughput is one word per cycle while tx is not stalled, set by the
//   single parse step between the input register and the result register
//   when tx stalls the result register holds its word, the input register
//   still takes one more rx word, then rx.ready drops until tx drains
//   reset clears both valid bits, the parser (back to hunting, length 0),
//   the text window and both sticky flags; a clear word does the same to
//   the parser, window and flags and still returns a framing result

module at_ipd_stream_deframer (
  input  logic           clk,
  input  logic           rst,
  aisd_in_if.sink        rx,
  aisd_out_if.source     tx
);

  // input register stage
  logic            s1_valid;
  aisd_pkg::item_t s1_item;

  // result register stage
  logic              res_valid;
  aisd_pkg::result_t res;

  logic               advance;
  aisd_pkg::step_t    ctl;
  aisd_pkg::prs_out_t prs;
  logic               closed_next;

  // a parsed word moves into the result register when that slot is free
  assign advance  = s1_valid && (!res_valid || tx.ready);
  assign rx.ready = !s1_valid || advance;

  assign ctl.step  = advance;
  assign ctl.clear = (s1_item.action == aisd_pkg::ACT_CLEAR);
  assign ctl.data  = s1_item.in_byte;

  aisd_parser u_parser (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .res (prs)
  );

  aisd_window u_window (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .rec_en      (prs.rec_en),
    .closed_next (closed_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (rx.ready) begin
        s1_valid <= rx.valid;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (tx.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      s1_item.action  <= rx.action;
      s1_item.in_byte <= rx.in_byte;
    end
    if (advance) begin
      res.kind         <= prs.kind;
      res.out_byte     <= prs.out_byte;
      res.payload_last <= prs.payload_last;
      res.link_closed  <= closed_next;
      res.length_error <= prs.length_error;
    end
  end

  assign tx.valid        = res_valid;
  assign tx.kind         = res.kind;
  assign tx.out_byte     = res.out_byte;
  assign tx.payload_last = res.payload_last;
  assign tx.link_closed  = res.link_closed;
  assign tx.length_error = res.length_error;

endmodule

@@ dv/at_ipd_stream_deframer_tb.sv @@
`timescale 1ns / 1ps
// at_ipd_stream_deframer_tb: self-checking bench for the +IPD modem stream deframer
// depends on aisd_pkg, aisd_if and the at_ipd_stream_deframer rtl

module at_ipd_stream_deframer_tb;

  // parser phases of the frame tracker kept inside the bench
  typedef enum logic [1:0] {PH_HUNT, PH_LEN, PH_SKIP, PH_PAYLOAD} frame_phase_t;

  // one row of the directed table; want is used only when typed is set
  typedef struct {
    logic    act;
    logic [7:0] data;
    bit      typed;
    aisd_pkg::result_t want;
  } dir_row_t;

  localparam int NUM_DIR   = 25;
  localparam int NUM_WORDS = 550;

  logic clk;
  logic rst;

  aisd_in_if  rx ();
  aisd_out_if tx ();

  at_ipd_stream_deframer DUT (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .tx  (tx)
  );

  // tracker state, mirrors what the block should hold
  frame_phase_t frm_phase;
  logic [2:0]   hdr_pos;
  logic [15:0]  len_left;
  logic [7:0]   text_win [aisd_pkg::WIN_DEPTH];
  logic         closed_seen;
  logic         len_err_seen;

  aisd_pkg::result_t expected_results [$];
  int      fail_count = 0;
  int      sent_words = 0;
  bit      calm = 1'b0;  // when set both sides run without gaps

  // directed words: clear, a one-byte frame, length overflow, clear, prefix restart
  dir_row_t dir_rows [NUM_DIR] = '{
    '{aisd_pkg::ACT_CLEAR, 8'hA5, 1'b1, {aisd_pkg::KIND_FRAMING, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{aisd_pkg::ACT_BYTE,  "+",   1'b1, {aisd_pkg::KIND_FRAMING, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{aisd_pkg::ACT_BYTE,  "I",   1'b1, {aisd_pkg::KIND_FRAMING, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{aisd_pkg::ACT_BYTE,  "P",   1'b1, {aisd_pkg::KIND_FRAMING, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{aisd_pkg::ACT_BYTE,  "D",   1'b1, {aisd_pkg::KIND_FRAMING, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{aisd_pkg::ACT_BYTE,  ",",   1'b1, {aisd_pkg::KIND_FRAMING, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{aisd_pkg::ACT_BYTE,  "1",   1'b1, {aisd_pkg::KIND_FRAMING, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{aisd_pkg::ACT_BYTE,  ":",   1'b1, {aisd_pkg::KIND_FRAMING, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{aisd_pkg::ACT_BYTE,  8'hFF, 1'b1, {aisd_pkg::KIND_PAYLOAD, 8'hFF, 1'b1, 1'b0, 1'b0}},
    '{aisd_pkg::ACT_BYTE,  8'h00, 1'b1, {aisd_pkg::KIND_TEXT,    8'h00, 1'b0, 1'b0, 1'b0}},
    '{aisd_pkg::ACT_BYTE,  "+",   1'b0, '0},
    '{aisd_pkg::ACT_BYTE,  "I",   1'b0, '0},
    '{aisd_pkg::ACT_BYTE,  "P",   1'b0, '0},
    '{aisd_pkg::ACT_BYTE,  "D",   1'b0, '0},
    '{aisd_pkg::ACT_BYTE,  ",",   1'b0, '0},
    '{aisd_pkg::ACT_BYTE,  "7",   1'b0, '0},
    '{aisd_pkg::ACT_BYTE,  "0",   1'b0, '0},
    '{aisd_pkg::ACT_BYTE,  "0",   1'b0, '0},
    '{aisd_pkg::ACT_BYTE,  "0",   1'b0, '0},
    '{aisd_pkg::ACT_BYTE,  "0",   1'b1, {aisd_pkg::KIND_FRAMING, 8'h00, 1'b0, 1'b0, 1'b1}},
    '{aisd_pkg::ACT_BYTE,  "Z",   1'b1, {aisd_pkg::KIND_TEXT,    "Z",   1'b0, 1'b0, 1'b1}},
    '{aisd_pkg::ACT_CLEAR, 8'h00, 1'b1, {aisd_pkg::KIND_FRAMING, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{aisd_pkg::ACT_BYTE,  "+",   1'b0, '0},
    '{aisd_pkg::ACT_BYTE,  "+",   1'b0, '0},
    '{aisd_pkg::ACT_BYTE,  "Q",   1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // frame tracker
  // ---------------------------------------------------------------------------

  function automatic void clear_tracker();
    frm_phase    = PH_HUNT;
    hdr_pos      = '0;
    len_left     = '0;
    closed_seen  = 1'b0;
    len_err_seen = 1'b0;
    for (int i = 0; i < aisd_pkg::WIN_DEPTH; i++) text_win[i] = '0;
  endfunction

  // true when the newest n window bytes spell s (first char in the top byte)
  function automatic bit window_ends_with(input logic [135:0] s, input int n);
    bit hit;
    hit = 1'b1;
    for (int i = 0; i < n; i++)
      if (text_win[aisd_pkg::WIN_DEPTH - n + i] != s[(n - 1 - i) * 8 +: 8]) hit = 1'b0;
    return hit;
  endfunction

  // shift a hunting byte into the window and look for a disconnect string
  function automatic void note_text(input logic [7:0] b);
    for (int i = 0; i < aisd_pkg::WIN_DEPTH - 1; i++) text_win[i] = text_win[i + 1];
    text_win[aisd_pkg::WIN_DEPTH - 1] = b;
    if (window_ends_with(136'(aisd_pkg::DISC_A), aisd_pkg::DISC_A_LEN) ||
        window_ends_with(136'(aisd_pkg::DISC_B), aisd_pkg::DISC_B_LEN) ||
        window_ends_with(aisd_pkg::DISC_C, aisd_pkg::DISC_C_LEN))
      closed_seen = 1'b1;
  endfunction

  // ':' after the header: a zero length drops straight back to hunting
  function automatic void close_header();
    frm_phase = (len_left == 0) ? PH_HUNT : PH_PAYLOAD;
    hdr_pos   = '0;
  endfunction

  // advance the tracker by one accepted word and return the result it implies
  function automatic aisd_pkg::result_t predict_word(input logic act, input logic [7:0] b);
    aisd_pkg::result_t r;
    logic [2:0]  pos;
    logic [19:0] acc;
    r = '0;
    if (act == aisd_pkg::ACT_CLEAR) begin
      clear_tracker();
    end else begin
      case (frm_phase)
        PH_PAYLOAD: begin
          r.kind     = aisd_pkg::KIND_PAYLOAD;
          r.out_byte = b;
          if (len_left <= 1) begin
            r.payload_last = 1'b1;
            len_left       = '0;
            frm_phase      = PH_HUNT;
            hdr_pos        = '0;
          end else begin
            len_left = len_left - 1'b1;
          end
        end
        PH_HUNT: begin
          pos = (hdr_pos > 4) ? 3'd0 : hdr_pos;
          if (b == aisd_pkg::HDR_TEXT[(4 - pos) * 8 +: 8]) begin
            pos = pos + 1'b1;
            if (pos == 5) begin
              frm_phase = PH_LEN;
              len_left  = '0;
              pos       = '0;
            end
            hdr_pos = pos;
          end else begin
            // a '+' that breaks the prefix starts a new one and is swallowed
            hdr_pos = (b == aisd_pkg::CH_PLUS) ? 3'd1 : 3'd0;
            note_text(b);
            if (b != aisd_pkg::CH_PLUS) begin
              r.kind     = aisd_pkg::KIND_TEXT;
              r.out_byte = b;
            end
          end
        end
        PH_LEN: begin
          if (b >= aisd_pkg::CH_ZERO && b <= aisd_pkg::CH_NINE) begin
            acc = {4'd0, len_left} * 20'd10 + {12'd0, b - aisd_pkg::CH_ZERO};
            if (acc > aisd_pkg::MAX_LEN) begin
              len_err_seen = 1'b1;
              len_left     = '0;
              frm_phase    = PH_HUNT;
              hdr_pos      = '0;
            end else begin
              len_left = acc[15:0];
            end
          end else if (b == aisd_pkg::CH_COLON) begin
            close_header();
          end else if (b == aisd_pkg::CH_COMMA) begin
            frm_phase = PH_SKIP;
          end else begin
            frm_phase = PH_HUNT;
            hdr_pos   = '0;
          end
        end
        default: begin
          if (b == aisd_pkg::CH_COLON) close_header();
        end
      endcase
    end
    r.link_closed  = closed_seen;
    r.length_error = len_err_seen;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // clock, idling and the word sender
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly back to back, now and then a short pause, rarely a long one
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one word, wait for it to be taken, then log what should come back
  task automatic send_word(input logic act, input logic [7:0] b, input bit typed,
                           input aisd_pkg::result_t typed_res);
    int      gap;
    aisd_pkg::result_t model_res;
    gap = idle_len();
    if (gap > 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx.valid   <= 1'b1;
    rx.action  <= act;
    rx.in_byte <= b;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
    // the tracker always advances, even where the row gives its own answer
    model_res = predict_word(act, b);
    expected_results.push_back(typed ? typed_res : model_res);
    sent_words++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(aisd_pkg::ACT_BYTE, b, 1'b0, '0);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // well-formed frame, optionally with extra header fields before ':'
  task automatic send_frame(input int len, input bit lead_zero, input bit with_fields);
    int         n;
    logic [7:0] b;
    send_text("+IPD,");
    if (lead_zero) send_byte(aisd_pkg::CH_ZERO);
    send_text($sformatf("%0d", len));
    if (with_fields) begin
      send_byte(aisd_pkg::CH_COMMA);
      n = $urandom_range(0, 10);
      for (int i = 0; i < n; i++) begin
        do b = 8'($urandom_range(0, 255)); while (b == aisd_pkg::CH_COLON);
        send_byte(b);
      end
    end
    send_byte(aisd_pkg::CH_COLON);
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  // any byte that is neither a digit, ',' nor ':' ends a length field
  function automatic logic [7:0] bad_len_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while ((b >= aisd_pkg::CH_ZERO && b <= aisd_pkg::CH_NINE) ||
           b == aisd_pkg::CH_COMMA || b == aisd_pkg::CH_COLON);
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // result sink: random back-pressure, with calm stretches
  // ---------------------------------------------------------------------------

  initial begin
    int gap;
    tx.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      tx.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      gap = idle_len();
      if (gap > 0) begin
        tx.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: each word on tx against the oldest expectation
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    aisd_pkg::result_t got;
    aisd_pkg::result_t want;
    if (!rst && tx.valid && tx.ready) begin
      got = {tx.kind, tx.out_byte, tx.payload_last, tx.link_closed, tx.length_error};
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: kind %0d byte %02h", got.kind,
               got.out_byte);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.kind != want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, got.kind);
          fail_count++;
        end
        if (got.out_byte != want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
          fail_count++;
        end
        if (got.payload_last != want.payload_last) begin
          $error("payload_last: expected %0b, got %0b", want.payload_last, got.payload_last);
          fail_count++;
        end
        if (got.link_closed != want.link_closed) begin
          $error("link_closed: expected %0b, got %0b", want.link_closed, got.link_closed);
          fail_count++;
        end
        if (got.length_error != want.length_error) begin
          $error("length_error: expected %0b, got %0b", want.length_error, got.length_error);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    string      disc_words [3];
    string      hdr_str;
    int         pick;
    int         k;
    int         n;
    logic [7:0] b;

    disc_words[0] = "WIFI DISCONNECT";
    disc_words[1] = "CLOSED";
    disc_words[2] = "link is not valid";
    hdr_str       = "+IPD,";

    rst        <= 1'b1;
    rx.valid   <= 1'b0;
    rx.action  <= aisd_pkg::ACT_BYTE;
    rx.in_byte <= '0;
    clear_tracker();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < NUM_DIR; i++)
      send_word(dir_rows[i].act, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);

    // random traffic, frames with random content most often
    while (sent_words < NUM_WORDS) begin
      calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        k = $urandom_range(0, 99);
        if (k < 5)       n = 0;
        else if (k < 85) n = $urandom_range(1, 16);
        else             n = $urandom_range(17, 200);
        send_frame(n, ($urandom_range(0, 7) == 0), ($urandom_range(0, 9) < 4));
      end else if (pick < 48) begin
        // length beyond 16 bits, or exactly at the limit and then cut off
        send_text("+IPD,");
        k = $urandom_range(0, 3);
        if (k == 0) begin
          send_text("65535");
          send_byte(bad_len_char());
        end else if (k == 1) begin
          send_text("65536");
        end else begin
          send_text($sformatf("%0d", $urandom_range(65537, 999999)));
        end
      end else if (pick < 56) begin
        // broken length field
        send_text("+IPD,");
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) send_byte(8'(aisd_pkg::CH_ZERO + $urandom_range(0, 9)));
        send_byte(bad_len_char());
      end else if (pick < 64) begin
        // partial prefix, then a byte that may or may not continue it
        k = $urandom_range(1, 4);
        send_text(hdr_str.substr(0, k - 1));
        b = ($urandom_range(0, 9) < 3) ? aisd_pkg::CH_PLUS : 8'($urandom_range(0, 255));
        send_byte(b);
      end else if (pick < 72) begin
        // disconnect notice in the text stream, often cleared afterwards
        if ($urandom_range(0, 1)) begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) send_byte(8'($urandom_range(8'h20, 8'h7E)));
        end
        send_text(disc_words[$urandom_range(0, 2)]);
        if ($urandom_range(0, 9) < 4)
          send_word(aisd_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)), 1'b0, '0);
      end else if (pick < 78) begin
        send_word(aisd_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)), 1'b0, '0);
      end else begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
      end
    end

    calm = 1'b0;
    rx.valid <= 1'b0;

    // drain, then a few more cycles to catch stray result words
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/aisd_pkg.sv
rtl/core/aisd_if.sv
rtl/core/aisd_parser.sv
rtl/core/aisd_window.sv
rtl/core/at_ipd_stream_deframer.sv
dv/at_ipd_stream_deframer_tb.sv
